// ===== src/lephist_pkg.sv =====
package lephist_pkg;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_RUN   = 1'b0,
		ST_CLEAR = 1'b1
	} hist_state_t;

	// highest k whose e^k threshold fits in a 32-bit energy
	localparam int EXP_TOP = 22;

	// floor(e^k), k = 0..22 (entry 0 unused)
	localparam logic [31:0] EXP_INT [0:22] = '{
		32'd0, 32'd2, 32'd7, 32'd20, 32'd54, 32'd148, 32'd403, 32'd1096,
		32'd2980, 32'd8103, 32'd22026, 32'd59874, 32'd162754, 32'd442413,
		32'd1202604, 32'd3269017, 32'd8886110, 32'd24154952, 32'd65659969,
		32'd178482300, 32'd485165195, 32'd1318815734, 32'd3584912846
	};

	// floor(frac(e^k) * 2^16)
	localparam logic [15:0] EXP_FRAC16 [0:22] = '{
		16'd0, 16'd47073, 16'd25497, 16'd5605, 16'd39200, 16'd27076,
		16'd28101, 16'd41494, 16'd62782, 16'd5500, 16'd30526, 16'd9287,
		16'd51866, 16'd25690, 16'd18623, 16'd24410, 16'd34112, 16'd49386,
		16'd9000, 16'd63123, 16'd26856, 16'd31667, 16'd8623
	};

	// ceil(e^k * 2^fb) as a raw fixed-point energy threshold
	function automatic logic [63:0] energy_threshold(input logic [4:0] k, input int fb);
		logic [63:0] ip;
		logic [63:0] fp;
		ip = 64'(EXP_INT[k]);
		fp = 64'(EXP_FRAC16[k]);
		return (ip << fb) + (fp >> (16 - fb)) + 64'd1;
	endfunction

endpackage

// ===== src/log_energy_position_histogram_core.sv =====
// channel | valid     | stall     | fields
// --------+-----------+-----------+----------------------------------------------------
// in      | in_valid  | in_stall  | cmd energy position sel_energy_bin
//         |           |           | sel_position_bin add_amount
// out     | out_valid | out_stall | bin_count total_events was_counted out_of_range
//         |           |           | hit_energy_bin hit_position_bin
//
// Record, add and read take one item per cycle unless stalled: bin decode, counter RAM
// read, read-modify-write with forwarding of the previous write.
// Clear stalls input, then sweeps the counter RAM one entry per cycle:
// ENERGY_BINS*POSITION_BINS entries (16384 by default).
// After reset the same sweep runs before the first item is taken.
// A stalled output freezes the whole pipeline, RAM read included.
module log_energy_position_histogram_core #(
	parameter int ENERGY_BINS   = 16,
	parameter int POSITION_BINS = 1024,
	parameter int COUNT_WIDTH   = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [1:0]  cmd,
	input  logic        [31:0] energy,
	input  logic signed [31:0] position,
	input  logic        [3:0]  sel_energy_bin,
	input  logic        [9:0]  sel_position_bin,
	input  logic        [31:0] add_amount,

	output logic               out_valid,
	input  logic               out_stall,
	output logic        [31:0] bin_count,
	output logic        [31:0] total_events,
	output logic               was_counted,
	output logic               out_of_range,
	output logic        [3:0]  hit_energy_bin,
	output logic        [9:0]  hit_position_bin
);

	localparam int DEPTH = ENERGY_BINS * POSITION_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(ENERGY_BINS);
	localparam int PW    = $clog2(POSITION_BINS);
	localparam int NK    = (ENERGY_BINS - 1 < lephist_pkg::EXP_TOP) ?
	                       ENERGY_BINS - 1 : lephist_pkg::EXP_TOP;
	localparam int SW    = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

	localparam logic [AW-1:0]          PB_A      = AW'(POSITION_BINS);
	localparam logic [AW-1:0]          LAST_IDX  = AW'(DEPTH - 1);
	localparam logic [31:0]            PB_32     = 32'(POSITION_BINS);
	localparam logic [6:0]             EB_7      = 7'(ENERGY_BINS);
	localparam logic [16:0]            PB_17     = 17'(POSITION_BINS);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [SW-1:0]          CMAX_W    = SW'(COUNT_MAX);
	localparam logic [SW-1:0]          SHOW_MAX  = SW'(32'hFFFF_FFFF);

	typedef struct packed {
		lephist_pkg::cmd_t cmd;
		logic [AW-1:0]     addr;
		logic              access;
		logic              write;
		logic [31:0]       amt;
		logic              counted;
		logic              oor;
		logic [3:0]        he;
		logic [9:0]        hp;
		logic [31:0]       total;
	} stage_t;

	lephist_pkg::hist_state_t state_q, state_d;
	logic [AW-1:0] clr_idx_q, clr_idx_d;

	logic   valid_s1, valid_s2;
	stage_t st_s1, st_s2, acc;
	logic   advance, accept;

	logic [31:0] event_total_q, total_next;

	logic [31:0]   pos_u, pos_mag, pbin_w;
	logic          pos_drop, sel_oor;
	logic [EW-1:0] ebin, se;
	logic [PW-1:0] pbin, sp;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                   fwd_valid_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	logic [COUNT_WIDTH-1:0] cur, newv;
	logic [SW-1:0]          sum;
	logic [31:0]            shown;
	logic                   wr_run;

	logic        out_valid_q;
	logic [31:0] bin_count_q, total_q;
	logic        counted_q, oor_q;
	logic [3:0]  he_q;
	logic [9:0]  hp_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != lephist_pkg::ST_RUN) || !advance
	                  || (valid_s1 && st_s1.cmd == lephist_pkg::CMD_CLEAR)
	                  || (valid_s2 && st_s2.cmd == lephist_pkg::CMD_CLEAR);
	assign accept   = in_valid && !in_stall;

	// bin decode
	always_comb begin
		pos_u   = unsigned'(position);
		pos_mag = ~pos_u + 32'd1;
		if (pos_u[31]) begin
			pos_drop = (pos_mag >> FRACTION_BITS) != 32'd0;
			pbin_w   = 32'd0;
		end else begin
			pos_drop = 1'b0;
			pbin_w   = pos_u >> FRACTION_BITS;
		end
		pbin = PW'(pbin_w);

		ebin = '0;
		for (int k = 1; k <= lephist_pkg::EXP_TOP; k++) begin
			if (k <= NK && {32'd0, energy} >=
			    lephist_pkg::energy_threshold(5'(k), FRACTION_BITS)) begin
				ebin = EW'(k);
			end
		end

		se      = EW'(sel_energy_bin);
		sp      = PW'(sel_position_bin);
		sel_oor = ({3'd0, sel_energy_bin} >= EB_7) || ({7'd0, sel_position_bin} >= PB_17);

		if (lephist_pkg::cmd_t'(cmd) == lephist_pkg::CMD_RECORD
		    && event_total_q != 32'hFFFF_FFFF) begin
			total_next = event_total_q + 32'd1;
		end else begin
			total_next = event_total_q;
		end

		acc       = '0;
		acc.cmd   = lephist_pkg::cmd_t'(cmd);
		acc.total = total_next;
		case (lephist_pkg::cmd_t'(cmd))
			lephist_pkg::CMD_RECORD: begin
				if (!pos_drop) begin
					if (pbin_w >= PB_32) begin
						acc.oor = 1'b1;
					end else begin
						acc.access  = 1'b1;
						acc.write   = 1'b1;
						acc.counted = 1'b1;
						acc.amt     = 32'd1;
						acc.addr    = AW'(ebin) * PB_A + AW'(pbin);
						acc.he      = 4'(ebin);
						acc.hp      = 10'(pbin);
					end
				end
			end
			lephist_pkg::CMD_ADD, lephist_pkg::CMD_READ: begin
				acc.he = sel_energy_bin;
				acc.hp = sel_position_bin;
				if (sel_oor) begin
					acc.oor = 1'b1;
				end else begin
					acc.access = 1'b1;
					acc.write  = (lephist_pkg::cmd_t'(cmd) == lephist_pkg::CMD_ADD);
					acc.amt    = (lephist_pkg::cmd_t'(cmd) == lephist_pkg::CMD_ADD) ?
					             add_amount : 32'd0;
					acc.addr   = AW'(se) * PB_A + AW'(sp);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_total_q <= '0;
		end else if (accept) begin
			event_total_q <= total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s1 <= acc;
			st_s2 <= st_s1;
		end
	end

	// read-modify-write, forwarding the write made while this item was reading
	always_comb begin
		cur    = (fwd_valid_q && fwd_addr_q == st_s2.addr) ? fwd_data_q : ram_rdata;
		sum    = SW'(cur) + SW'(st_s2.amt);
		newv   = (sum > CMAX_W) ? COUNT_MAX : COUNT_WIDTH'(sum);
		shown  = (SW'(newv) > SHOW_MAX) ? 32'hFFFF_FFFF : 32'(newv);
		wr_run = valid_s2 && st_s2.write && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (state_q == lephist_pkg::ST_CLEAR) begin
			fwd_valid_q <= 1'b0;
		end else if (advance) begin
			fwd_valid_q <= wr_run;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_addr_q <= st_s2.addr;
			fwd_data_q <= newv;
		end
	end

	// sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lephist_pkg::ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_idx_q <= clr_idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_idx_d = clr_idx_q;
		ram_we    = 1'b0;
		ram_waddr = st_s2.addr;
		ram_wdata = newv;
		case (state_q)
			lephist_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
				if (clr_idx_q == LAST_IDX) begin
					clr_idx_d = '0;
					state_d   = lephist_pkg::ST_RUN;
				end else begin
					clr_idx_d = clr_idx_q + AW'(1);
				end
			end
			lephist_pkg::ST_RUN: begin
				ram_we = wr_run;
				if (valid_s2 && advance && st_s2.cmd == lephist_pkg::CMD_CLEAR) begin
					state_d = lephist_pkg::ST_CLEAR;
				end
			end
			default: begin
				state_d = lephist_pkg::ST_CLEAR;
			end
		endcase
	end

	lephist_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (advance),
		.raddr (st_s1.addr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			bin_count_q <= st_s2.access ? shown : 32'd0;
			total_q     <= st_s2.total;
			counted_q   <= st_s2.counted;
			oor_q       <= st_s2.oor;
			he_q        <= st_s2.he;
			hp_q        <= st_s2.hp;
		end
	end

	assign out_valid        = out_valid_q;
	assign bin_count        = bin_count_q;
	assign total_events     = total_q;
	assign was_counted      = counted_q;
	assign out_of_range     = oor_q;
	assign hit_energy_bin   = he_q;
	assign hit_position_bin = hp_q;

endmodule

// ===== src/lephist_ram.sv =====
module lephist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
